@@ rtl/nearest_actuator_dispatch_top_defines.svh @@
// Assertion helpers for the checker file, nad_checker.sv.
`ifndef NEAREST_ACTUATOR_DISPATCH_TOP_DEFINES_SVH
`define NEAREST_ACTUATOR_DISPATCH_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define NAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define NAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nad_pkg.sv @@
package nad_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_BITS_DEF = 8;

  localparam int SLOT_W  = 4;
  localparam int POS_W   = 8;
  localparam int LEVEL_W = 16;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_EFFECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } nad_state_e;

endpackage

@@ rtl/nad_point_mem.sv @@
module nad_point_mem #(
  parameter int DEPTH = nad_pkg::MAX_POINTS_DEF,
  parameter int WIDTH = 2 * nad_pkg::COORD_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/nearest_actuator_dispatch_top.sv @@
// Channel | Direction | Handshake             | Payload
// in      | to block  | in_valid_i/in_stall_o  | kind, slot, slot_enable, pos_x, pos_y, level
// out     | from block| out_valid_o/out_stall_i| chosen_slot/x/y, applied_level, exact_hit,
//         |           |                        | table_empty
//
// A load request writes the point memory and leaves the block idle. An effect request
// passes through SCAN, DRAIN and DONE before the next request is taken; SCAN uses the
// single read port of the point memory, scanned one slot per cycle.
// Reset clears the slot valid flops at once; no clearing pass is needed.
// A result waits in the output register while new requests are taken; a finished
// effect holds in its last state until that register is free.
module nearest_actuator_dispatch_top #(
  parameter int MAX_POINTS = nad_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = nad_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [nad_pkg::SLOT_W-1:0]  slot_i,
  input  logic                       slot_enable_i,
  input  logic [nad_pkg::POS_W-1:0]   pos_x_i,
  input  logic [nad_pkg::POS_W-1:0]   pos_y_i,
  input  logic [nad_pkg::LEVEL_W-1:0] level_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [nad_pkg::SLOT_W-1:0]  chosen_slot_o,
  output logic [nad_pkg::POS_W-1:0]   chosen_x_o,
  output logic [nad_pkg::POS_W-1:0]   chosen_y_o,
  output logic [nad_pkg::LEVEL_W-1:0] applied_level_o,
  output logic                       exact_hit_o,
  output logic                       table_empty_o
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = COORD_BITS;
  localparam int SW = 2 * CW;
  localparam int DW = SW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_POINTS - 1);

  nad_pkg::nad_state_e state_q, state_d;

  logic accept, load_acc, eff_acc, slot_ok;
  logic rd_en, out_load;
  logic [IW-1:0] load_idx;
  logic [CW-1:0] in_x, in_y;
  logic [SW-1:0] wr_data, rd_data;

  logic [MAX_POINTS-1:0] valid_q;
  logic [IW-1:0]         rd_idx_q;

  logic [CW-1:0] tgt_x_q, tgt_y_q;
  logic [nad_pkg::LEVEL_W-1:0] lvl_q;

  // read pipeline: p1 meets the memory data, p2 holds the squares
  logic          p1_vld_q, p1_ent_q;
  logic [IW-1:0] p1_idx_q;
  logic [CW-1:0] m_x, m_y, dx, dy;

  logic          p2_vld_q, p2_ent_q;
  logic [IW-1:0] p2_idx_q;
  logic [CW-1:0] p2_x_q, p2_y_q;
  logic [SW-1:0] p2_sqx_q, p2_sqy_q;

  logic          best_found_q;
  logic [DW-1:0] best_d_q, cand_d;
  logic [IW-1:0] best_idx_q;
  logic [CW-1:0] best_x_q, best_y_q;
  logic          better;

  logic                       out_valid_q;
  logic [nad_pkg::SLOT_W-1:0]  res_slot_q;
  logic [nad_pkg::POS_W-1:0]   res_x_q, res_y_q;
  logic [nad_pkg::LEVEL_W-1:0] res_lvl_q;
  logic                       res_exact_q, res_empty_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign slot_ok  = int'(slot_i) < MAX_POINTS;
  assign load_acc = accept && (kind_i == nad_pkg::KIND_LOAD) && slot_ok;
  assign eff_acc  = accept && (kind_i == nad_pkg::KIND_EFFECT);
  assign load_idx = IW'(slot_i);
  assign in_x     = CW'(pos_x_i);
  assign in_y     = CW'(pos_y_i);
  assign wr_data  = slot_enable_i ? {in_x, in_y} : '0;

  nad_point_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (SW),
    .AW    (IW)
  ) u_point_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_acc),
    .wr_addr_i (load_idx),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      nad_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (eff_acc) begin
          state_d = nad_pkg::ST_SCAN;
        end
      end
      nad_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_idx_q == LAST_IDX) begin
          state_d = nad_pkg::ST_DRAIN;
        end
      end
      nad_pkg::ST_DRAIN: begin
        if (!p1_vld_q && !p2_vld_q) begin
          state_d = nad_pkg::ST_DONE;
        end
      end
      nad_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = nad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_idx_q <= '0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else begin
      if (load_acc) begin
        valid_q[load_idx] <= slot_enable_i;
      end
      if (eff_acc) begin
        rd_idx_q <= '0;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + IW'(1);
      end
      p1_vld_q <= rd_en;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eff_acc) begin
      tgt_x_q <= in_x;
      tgt_y_q <= in_y;
      lvl_q   <= level_i;
    end
  end

  assign m_x = rd_data[SW-1:CW];
  assign m_y = rd_data[CW-1:0];
  assign dx  = (tgt_x_q > m_x) ? tgt_x_q - m_x : m_x - tgt_x_q;
  assign dy  = (tgt_y_q > m_y) ? tgt_y_q - m_y : m_y - tgt_y_q;

  always_ff @(posedge clk_i) begin
    p1_idx_q <= rd_idx_q;
    p1_ent_q <= valid_q[rd_idx_q];
    p2_idx_q <= p1_idx_q;
    p2_ent_q <= p1_ent_q;
    p2_x_q   <= m_x;
    p2_y_q   <= m_y;
    p2_sqx_q <= SW'(dx) * SW'(dx);
    p2_sqy_q <= SW'(dy) * SW'(dy);
  end

  assign cand_d = DW'(p2_sqx_q) + DW'(p2_sqy_q);
  // ties: smaller x, then smaller y; equal positions keep the lower slot
  assign better = !best_found_q || (cand_d < best_d_q) ||
                  ((cand_d == best_d_q) && ((p2_x_q < best_x_q) ||
                   ((p2_x_q == best_x_q) && (p2_y_q < best_y_q))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
    end else if (eff_acc) begin
      best_found_q <= 1'b0;
    end else if (p2_vld_q && p2_ent_q && better) begin
      best_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_vld_q && p2_ent_q && better) begin
      best_d_q   <= cand_d;
      best_idx_q <= p2_idx_q;
      best_x_q   <= p2_x_q;
      best_y_q   <= p2_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // the applied level is the request's own level, or zero for an empty table: stored levels never feed a result
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_empty_q <= !best_found_q;
      res_slot_q  <= best_found_q ? nad_pkg::SLOT_W'(best_idx_q) : '0;
      res_x_q     <= best_found_q ? nad_pkg::POS_W'(best_x_q) : '0;
      res_y_q     <= best_found_q ? nad_pkg::POS_W'(best_y_q) : '0;
      res_lvl_q   <= best_found_q ? lvl_q : '0;
      res_exact_q <= best_found_q && (best_d_q == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_slot_o   = res_slot_q;
  assign chosen_x_o      = res_x_q;
  assign chosen_y_o      = res_y_q;
  assign applied_level_o = res_lvl_q;
  assign exact_hit_o     = res_exact_q;
  assign table_empty_o   = res_empty_q;

endmodule

@@ rtl/nad_checker.sv @@
`include "nearest_actuator_dispatch_top_defines.svh"

module nad_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       kind_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [nad_pkg::SLOT_W-1:0]  chosen_slot_o,
  input logic [nad_pkg::POS_W-1:0]   chosen_x_o,
  input logic [nad_pkg::POS_W-1:0]   chosen_y_o,
  input logic [nad_pkg::LEVEL_W-1:0] applied_level_o,
  input logic                       exact_hit_o,
  input logic                       table_empty_o
);

  `NAD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `NAD_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(chosen_slot_o) && $stable(applied_level_o), "stalled result changed")
  `NAD_ASSERT_NOW(a_empty_zero, out_valid_o && table_empty_o, chosen_slot_o == '0 && chosen_x_o == '0 && chosen_y_o == '0 && applied_level_o == '0 && !exact_hit_o, "empty-table result carries data")
  `NAD_ASSERT_NEXT(a_effect_busy, in_valid_i && !in_stall_o && kind_i == nad_pkg::KIND_EFFECT, in_stall_o, "effect request not followed by a busy scan")

endmodule

bind nearest_actuator_dispatch_top nad_checker u_nad_checker (.*);
